/* design/dplru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dplru_pkg
// Shared types and codes of the demand paging manager with per-process LRU.
// ----------------------------------------------------------------------------
package dplru_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 6;
  localparam int FCOUNT_W      = 6;
  localparam int PCOUNT_W      = 5;
  localparam int NUM_PAGE_REGS = 4;
  localparam int SLOT_W        = 2;
  localparam int PAGE_NUM_W    = 8;
  localparam int STATUS_W      = 3;
  localparam int FRAME_OUT_W   = 5;
  localparam int VICTIM_OUT_W  = 4;
  localparam int STAMP_W       = 32;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 6'd32;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;

  localparam logic CMD_ACCESS  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_P0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_P1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_P2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_P3    = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_FAULT_FREE  = 3'd1,
    ST_FAULT_EVICT = 3'd2,
    ST_UNSERVICED  = 3'd3,
    ST_INVALID     = 3'd4,
    ST_RELEASED    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_REL,
    S_FREE,
    S_LRU,
    S_EVICT,
    S_FILL,
    S_DONE
  } state_e;

endpackage : dplru_pkg
`default_nettype wire

/* design/dplru_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dplru_req_if / dplru_rsp_if
// Valid/ready channels for paging requests and their results.
// ----------------------------------------------------------------------------
interface dplru_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] process_slot;
  logic signed [7:0] page_number;

  modport source (output valid, cmd, process_slot, page_number, input ready);
  modport sink   (input valid, cmd, process_slot, page_number, output ready);
endinterface : dplru_req_if

interface dplru_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] frame;
  logic [3:0] victim_page;

  modport source (output valid, status, frame, victim_page, input ready);
  modport sink   (input valid, status, frame, victim_page, output ready);
endinterface : dplru_rsp_if
`default_nettype wire

/* design/demand_paging_lru_mmu_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_lru_mmu_core
// Demand paging manager: per-process page tables, free-frame map and
// least-recently-used replacement, one request at a time.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds its state in two
// single-port-read memories (page entries with their last-use stamps, and the
// frame-in-use map), each with a registered read. A hit reads and restamps its
// entry; a release or invalid page in a valid slot scans the slot's page
// entries; a fault served from a free frame adds a scan of the frame map over
// the usable frames (frame_count capped at FRAMES); a fault that must evict
// adds that full scan (skipped when no frame is usable) plus an LRU scan over
// the slot's pages and the write-back states S_EVICT and S_FILL.
// After reset a clearing pass over the page entries and the frame map runs
// before the first request is taken; configuration writes are taken
// throughout. A finished result waits in an output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
module demand_paging_lru_mmu_core #(
  parameter int PROCESSES = 4,
  parameter int PAGES     = 16,
  parameter int FRAMES    = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [dplru_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [dplru_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  dplru_req_if.sink                             req_i,
  dplru_rsp_if.source                           rsp_o
);
  import dplru_pkg::*;

  localparam int ENTRIES = PROCESSES * PAGES;
  localparam int FW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PW      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW      = $clog2(FRAMES + 1);
  localparam int PCW     = $clog2(PAGES + 1);
  localparam int XW      = ((CW > PCW) ? CW : PCW) + 1;
  localparam int CLR_LEN = (ENTRIES > FRAMES) ? ENTRIES : FRAMES;
  localparam int KW      = $clog2(CLR_LEN + 1);

  typedef struct packed {
    logic               vld;
    logic [FW-1:0]      frame;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  // memories
  ent_t               ent_mem  [ENTRIES];
  logic               used_mem [FRAMES];

  ent_t               ent_rdata_q;
  logic               used_rdata_q;

  logic [EW-1:0]      ent_raddr;
  logic [FW-1:0]      used_raddr;
  logic               ent_we, used_we;
  logic [EW-1:0]      ent_waddr;
  ent_t               ent_wdata;
  logic [FW-1:0]      used_waddr;
  logic               used_wdata;

  // configuration
  logic [FCOUNT_W-1:0] fc_q;
  logic [PCOUNT_W-1:0] pc_q [NUM_PAGE_REGS];

  // control
  state_e             state_q, state_d;
  logic [STAMP_W-1:0] tick_q;
  logic [KW-1:0]      clr_q;
  logic [XW-1:0]      idx_q;
  logic [XW-1:0]      p_idx_q;
  logic               p_vld_q, p_last_q;
  logic               a_vld_q, a_last_q;
  logic               found_q;
  logic               rsp_vld_q;

  // payload
  logic [EW-1:0]      base_q, e_q;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] a_age_q, best_age_q;
  logic [PW-1:0]      a_idx_q, best_idx_q;
  logic [FW-1:0]      a_frame_q, best_frame_q;
  status_e            res_status_q;
  logic [FW-1:0]      res_frame_q;
  logic [PW-1:0]      res_victim_q;
  logic [STATUS_W-1:0]     rsp_status_q;
  logic [FRAME_OUT_W-1:0]  rsp_frame_q;
  logic [VICTIM_OUT_W-1:0] rsp_victim_q;

  // derived signals
  logic               accept;
  logic               slot_ok, page_ok, is_release;
  int                 limit;
  logic [EW-1:0]      req_base, req_e, scan_addr;
  logic [CW-1:0]      usable;
  logic [XW-1:0]      lim;
  logic               free_hit, p_end, lru_upd, lru_found;
  logic               rsp_load;
  logic [8:0]         frame_ext;
  logic [6:0]         victim_ext;

  assign accept     = req_i.valid && req_i.ready;
  assign is_release = (req_i.cmd == CMD_RELEASE);
  assign slot_ok    = int'(req_i.process_slot) < PROCESSES;

  always_comb begin
    limit = 0;
    if (slot_ok) begin
      limit = (int'(pc_q[req_i.process_slot]) > PAGES) ? PAGES
                                                        : int'(pc_q[req_i.process_slot]);
    end
  end

  assign page_ok  = slot_ok && !req_i.page_number[7] &&
                    (int'(req_i.page_number[6:0]) < limit);
  assign req_base = EW'(int'(req_i.process_slot) * PAGES);
  assign req_e    = EW'(int'(req_i.process_slot) * PAGES +
                        int'(req_i.page_number[PW-1:0]));

  assign usable   = (int'(fc_q) > FRAMES) ? CW'(FRAMES) : CW'(fc_q);
  assign lim      = (state_q == S_FREE) ? XW'(usable) : XW'(PAGES);

  assign scan_addr = EW'(int'(base_q) + int'(idx_q[PW-1:0]));
  assign free_hit  = p_vld_q && !used_rdata_q;
  assign p_end     = p_vld_q && p_last_q;
  assign lru_upd   = a_vld_q && (!found_q || (a_age_q > best_age_q));
  assign lru_found = found_q || a_vld_q;
  assign rsp_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (int'(clr_q) == CLR_LEN - 1) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (is_release || !page_ok) begin
            state_d = slot_ok ? S_REL : S_DONE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ent_rdata_q.vld) begin
          state_d = S_DONE;
        end else if (usable == '0) begin
          state_d = S_LRU;
        end else begin
          state_d = S_FREE;
        end
      end
      S_REL:   if (p_end) state_d = S_DONE;
      S_FREE: begin
        if (free_hit) begin
          state_d = S_DONE;
        end else if (p_end) begin
          state_d = S_LRU;
        end
      end
      S_LRU:   if (a_last_q) state_d = lru_found ? S_EVICT : S_DONE;
      S_EVICT: state_d = S_FILL;
      S_FILL:  state_d = S_DONE;
      S_DONE:  if (rsp_load) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    ent_raddr   = scan_addr;
    used_raddr  = idx_q[FW-1:0];
    ent_we      = 1'b0;
    ent_waddr   = e_q;
    ent_wdata   = '0;
    used_we     = 1'b0;
    used_waddr  = p_idx_q[FW-1:0];
    used_wdata  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ent_we     = int'(clr_q) < ENTRIES;
        ent_waddr  = clr_q[EW-1:0];
        used_we    = int'(clr_q) < FRAMES;
        used_waddr = clr_q[FW-1:0];
      end
      S_IDLE: ent_raddr = req_e;
      S_CHECK: begin
        // restamp a hit in place
        ent_we    = ent_rdata_q.vld;
        ent_wdata = '{vld: 1'b1, frame: ent_rdata_q.frame, stamp: now_q};
      end
      S_REL: begin
        // drop every valid page of the slot and give its frames back
        if (p_vld_q && ent_rdata_q.vld) begin
          ent_we     = 1'b1;
          ent_waddr  = EW'(int'(base_q) + int'(p_idx_q[PW-1:0]));
          used_we    = 1'b1;
          used_waddr = ent_rdata_q.frame;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          used_we    = 1'b1;
          used_wdata = 1'b1;
          ent_we     = 1'b1;
          ent_wdata  = '{vld: 1'b1, frame: p_idx_q[FW-1:0], stamp: now_q};
        end
      end
      S_EVICT: begin
        ent_we    = 1'b1;
        ent_waddr = EW'(int'(base_q) + int'(best_idx_q));
      end
      S_FILL: begin
        ent_we    = 1'b1;
        ent_wdata = '{vld: 1'b1, frame: best_frame_q, stamp: now_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_rdata_q  <= ent_mem[ent_raddr];
    used_rdata_q <= used_mem[used_raddr];
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FCOUNT_RESET;
      for (int i = 0; i < NUM_PAGE_REGS; i++) begin
        pc_q[i] <= PCOUNT_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_COUNT: fc_q    <= cfg_data_i[FCOUNT_W-1:0];
        REG_PAGES_P0:    pc_q[0] <= cfg_data_i[PCOUNT_W-1:0];
        REG_PAGES_P1:    pc_q[1] <= cfg_data_i[PCOUNT_W-1:0];
        REG_PAGES_P2:    pc_q[2] <= cfg_data_i[PCOUNT_W-1:0];
        REG_PAGES_P3:    pc_q[3] <= cfg_data_i[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      tick_q    <= '0;
      clr_q     <= '0;
      idx_q     <= '0;
      p_idx_q   <= '0;
      p_vld_q   <= 1'b0;
      p_last_q  <= 1'b0;
      a_vld_q   <= 1'b0;
      a_last_q  <= 1'b0;
      found_q   <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        tick_q <= tick_q + 1'b1;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_d != state_q) begin
        // every scan starts from a clean pipeline
        idx_q    <= '0;
        p_vld_q  <= 1'b0;
        p_last_q <= 1'b0;
        a_vld_q  <= 1'b0;
        a_last_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (state_q == S_REL || state_q == S_FREE || state_q == S_LRU) begin
        idx_q    <= idx_q + 1'b1;
        p_idx_q  <= idx_q;
        p_vld_q  <= idx_q < lim;
        p_last_q <= idx_q == (lim - 1'b1);
        a_vld_q  <= p_vld_q && ent_rdata_q.vld;
        a_last_q <= p_end;
        found_q  <= lru_found;
      end
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q       <= req_base;
      e_q          <= req_e;
      now_q        <= tick_q;
      res_status_q <= is_release ? ST_RELEASED : ST_INVALID;
      res_frame_q  <= '0;
      res_victim_q <= '0;
    end
    case (state_q)
      S_CHECK: begin
        if (ent_rdata_q.vld) begin
          res_status_q <= ST_HIT;
          res_frame_q  <= ent_rdata_q.frame;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          res_status_q <= ST_FAULT_FREE;
          res_frame_q  <= p_idx_q[FW-1:0];
        end
      end
      S_LRU: begin
        a_age_q   <= now_q - ent_rdata_q.stamp;
        a_idx_q   <= p_idx_q[PW-1:0];
        a_frame_q <= ent_rdata_q.frame;
        if (lru_upd) begin
          best_age_q   <= a_age_q;
          best_idx_q   <= a_idx_q;
          best_frame_q <= a_frame_q;
        end
        if (a_last_q && !lru_found) begin
          res_status_q <= ST_UNSERVICED;
        end
      end
      S_EVICT: begin
        res_status_q <= ST_FAULT_EVICT;
        res_frame_q  <= best_frame_q;
        res_victim_q <= best_idx_q;
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_frame_q  <= frame_ext[FRAME_OUT_W-1:0];
      rsp_victim_q <= victim_ext[VICTIM_OUT_W-1:0];
    end
  end

  assign frame_ext  = 9'(res_frame_q);
  assign victim_ext = 7'(res_victim_q);

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.frame       = rsp_frame_q;
  assign rsp_o.victim_page = rsp_victim_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while previous one still in work");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rsp_vld_q && !rsp_o.ready) |=> (state_q == S_DONE))
    else $error("result overwritten before it was taken");

  a_victim_only_on_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_FAULT_EVICT) |-> (rsp_o.victim_page == '0))
    else $error("victim page reported without eviction");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE && free_hit) |-> (p_idx_q < XW'(usable)))
    else $error("free frame taken beyond usable count");

endmodule : demand_paging_lru_mmu_core
`default_nettype wire
